>>> rtl/core/okst_pkg.sv
// Shared constants for the ordered key set table: opcodes, field widths and
// parameter defaults. No dependencies.
`default_nettype none

package okst_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ERASE  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd3;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned KEY_WIDTH_DEF = 32;

endpackage

`default_nettype wire

>>> rtl/core/okst_req_if.sv
// Request channel of the ordered key set table: valid/ready plus payload.
// Depends on okst_pkg for field widths.
`default_nettype none

interface okst_req_if;
  logic                          valid;
  logic                          ready;
  logic [okst_pkg::OPCODE_W-1:0] opcode;
  logic [okst_pkg::KEY_W-1:0]    key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

`default_nettype wire

>>> rtl/core/okst_rsp_if.sv
// Result channel of the ordered key set table: valid/ready plus payload.
// Depends on okst_pkg for field widths.
`default_nettype none

interface okst_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         was_present;
  logic [okst_pkg::COUNT_W-1:0] count;
  logic                         is_empty;
  logic [okst_pkg::KEY_W-1:0]   oldest_key;
  logic                         insert_dropped;

  modport source (output valid, output was_present, output count, output is_empty,
                  output oldest_key, output insert_dropped, input ready);
  modport sink   (input valid, input was_present, input count, input is_empty,
                  input oldest_key, input insert_dropped, output ready);
endinterface

`default_nettype wire

>>> rtl/core/okst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module okst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/ordered_key_set_table.sv
// Ordered key set table: bounded set of distinct keys kept in insertion order.
// Depends on okst_pkg, okst_req_if, okst_rsp_if and okst_ram.
//
//   channel  dir  handshake    payload
//   req      in   valid/ready  opcode[1:0], key[31:0]
//   rsp      out  valid/ready  was_present, count[4:0], is_empty,
//                              oldest_key[31:0], insert_dropped
//
// A clear goes straight to the final state, which loads the result register;
// find, insert and erase scan the stored keys from slot 0 until a hit or the
// end of the set, then act. The key store is scanned one entry per cycle
// through its single read port and one shared comparator. Erase of a hit then
// shifts the later keys down one slot through the same port. A full output
// register holds the sequencer in its last state until the result is taken.
// Reset is synchronous and empties the set; the key store needs no clearing
// pass. A new request is taken once the sequencer is idle, even while the
// previous result still waits in the output register.
`default_nettype none

module ordered_key_set_table #(
  parameter int unsigned CAPACITY  = okst_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH = okst_pkg::KEY_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  okst_req_if.sink   req,
  okst_rsp_if.source rsp
);

  // Stored key width: capped at the port width; narrower keys read out with zero upper bits.
  localparam int unsigned SW = (KEY_WIDTH < okst_pkg::KEY_W) ? KEY_WIDTH : okst_pkg::KEY_W;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_ACT   = 3'd2;
  localparam logic [2:0] ST_SHIFT = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]                    state;
  logic [okst_pkg::OPCODE_W-1:0] op;
  logic [SW-1:0]                 key;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 scan_idx;
  logic                          rd_valid;
  logic [AW-1:0]                 rd_idx;
  logic [AW-1:0]                 pos;
  logic                          present;
  logic                          dropped;
  logic [SW-1:0]                 oldest;

  logic          we;
  logic [AW-1:0] waddr;
  logic [SW-1:0] wdata;
  logic [SW-1:0] rdata;
  logic          issue;
  logic          hit;

  okst_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_keys (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (scan_idx[AW-1:0]),
    .rdata (rdata)
  );

  // Read the next stored entry while the index is still inside the set.
  assign issue = (scan_idx < count);
  // The one shared comparator, fed by the registered read data.
  assign hit = rd_valid && (rdata == key);

  assign req.ready = (state == ST_IDLE);

  // Write port: append on insert, move an entry down one slot while shifting.
  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = key;
    case (state)
      ST_ACT: begin
        we = (op == okst_pkg::OP_INSERT) && !present && (count < CW'(CAPACITY));
      end
      ST_SHIFT: begin
        we    = rd_valid;
        waddr = AW'(rd_idx - 1'b1);
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // Drop the result once taken; the final state reloads it on its own.
      if (rsp.valid && rsp.ready && state != ST_FIN) begin
        rsp.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            op       <= req.opcode;
            key      <= req.key[SW-1:0];
            scan_idx <= '0;
            rd_valid <= 1'b0;
            present  <= 1'b0;
            dropped  <= 1'b0;
            if (req.opcode == okst_pkg::OP_CLEAR) begin
              count <= '0;
              state <= ST_FIN;
            end else begin
              state <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          if (hit) begin
            present <= 1'b1;
            pos     <= rd_idx;
            state   <= ST_ACT;
          end else if (!issue && !rd_valid) begin
            state <= ST_ACT;
          end else begin
            if (issue) begin
              scan_idx <= scan_idx + 1'b1;
            end
            rd_valid <= issue;
            rd_idx   <= scan_idx[AW-1:0];
          end
        end

        ST_ACT: begin
          state <= ST_FIN;
          if (op == okst_pkg::OP_INSERT && !present) begin
            if (count < CW'(CAPACITY)) begin
              if (count == '0) begin
                oldest <= key;
              end
              count <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
          end else if (op == okst_pkg::OP_ERASE && present) begin
            // Start moving keys from the slot after the hit.
            scan_idx <= CW'(pos) + 1'b1;
            rd_valid <= 1'b0;
            state    <= ST_SHIFT;
          end
        end

        ST_SHIFT: begin
          if (!issue && !rd_valid) begin
            count <= count - 1'b1;
            state <= ST_FIN;
          end else begin
            if (issue) begin
              scan_idx <= scan_idx + 1'b1;
            end
            rd_valid <= issue;
            rd_idx   <= scan_idx[AW-1:0];
            // The key moving into slot 0 becomes the new oldest.
            if (rd_valid && rd_idx == AW'(1)) begin
              oldest <= rdata;
            end
          end
        end

        ST_FIN: begin
          // Hold until the output register is free.
          if (!rsp.valid || rsp.ready) begin
            rsp.valid          <= 1'b1;
            rsp.was_present    <= present;
            rsp.count          <= okst_pkg::COUNT_W'(count);
            rsp.is_empty       <= (count == '0);
            rsp.oldest_key     <= (count == '0) ? '0 : okst_pkg::KEY_W'(oldest);
            rsp.insert_dropped <= dropped;
            state              <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != ST_IDLE))
    else $error("sequencer idle right after accepting an item");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_ACT || state == ST_SHIFT))
    else $error("key store written outside insert or shift");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.insert_dropped) |-> (rsp.count == okst_pkg::COUNT_W'(CAPACITY)))
    else $error("insert dropped while table not full");

  a_clear_absent: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && op == okst_pkg::OP_CLEAR) |-> (!present && count == '0))
    else $error("clear left keys or reported presence");
`endif

endmodule

`default_nettype wire
